### src/gwlp_pkg.sv
// ----------------------------------------------------------------------------
// gwlp_pkg: shared constants for the greedy wrap layout placer
// Register map indexes and configuration port sizes.
// ----------------------------------------------------------------------------
package gwlp_pkg;

  // Configuration port sizes
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned REG_IDX_BITS  = 3;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  // Register indexes (byte address is 4 * index)
  localparam reg_idx_t REG_ORIENTATION      = 3'd0;
  localparam reg_idx_t REG_STACK_MODE       = 3'd1;
  localparam reg_idx_t REG_AVAILABLE_EXTENT = 3'd2;
  localparam reg_idx_t REG_SPACING_X        = 3'd3;
  localparam reg_idx_t REG_SPACING_Y        = 3'd4;

endpackage

### src/gwlp_cfg.sv
// ----------------------------------------------------------------------------
// gwlp_cfg: configuration register file
// APB-style slave holding orientation, stack mode, available extent and the
// two spacings. Writes land on the access cycle; reads return the register.
// ----------------------------------------------------------------------------
module gwlp_cfg #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gwlp_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [gwlp_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [gwlp_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output logic                                 orientation,
  output logic                                 stack_mode,
  output logic [COORD_BITS-1:0]                available_extent,
  output logic [SIZE_BITS-1:0]                 spacing_x,
  output logic [SIZE_BITS-1:0]                 spacing_y
);

  localparam int unsigned DW = gwlp_pkg::CFG_DATA_BITS;

  gwlp_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gwlp_pkg::CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      orientation      <= 1'b1;
      stack_mode       <= 1'b0;
      available_extent <= '1;
      spacing_x        <= '0;
      spacing_y        <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        gwlp_pkg::REG_ORIENTATION:      orientation      <= pwdata[0];
        gwlp_pkg::REG_STACK_MODE:       stack_mode       <= pwdata[0];
        gwlp_pkg::REG_AVAILABLE_EXTENT: available_extent <= pwdata[COORD_BITS-1:0];
        gwlp_pkg::REG_SPACING_X:        spacing_x        <= pwdata[SIZE_BITS-1:0];
        gwlp_pkg::REG_SPACING_Y:        spacing_y        <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_idx)
      gwlp_pkg::REG_ORIENTATION:      prdata = DW'(orientation);
      gwlp_pkg::REG_STACK_MODE:       prdata = DW'(stack_mode);
      gwlp_pkg::REG_AVAILABLE_EXTENT: prdata = DW'(available_extent);
      gwlp_pkg::REG_SPACING_X:        prdata = DW'(spacing_x);
      gwlp_pkg::REG_SPACING_Y:        prdata = DW'(spacing_y);
      default:                        prdata = '0;
    endcase
  end

endmodule

### src/greedy_wrap_layout_placer.sv
// ----------------------------------------------------------------------------
// greedy_wrap_layout_placer: streaming box placer with greedy line wrap
// Places one box per transaction along the main axis, wrapping to a new line
// when the box would pass the available extent (not in stack mode), and
// reports layout totals on the box marked last.
// ----------------------------------------------------------------------------
// One box is taken per cycle while not stalled, and its result appears in
// the output register in the cycle after the input transaction, so a steady
// stream runs at one box per cycle. The rate is set by the line state (line
// length, line thickness, cross cursor, longest line), which is updated in
// the same cycle the box is taken so that the next box can use it right away.
// The output register decouples the two sides: a new box is taken whenever
// the output register is empty or its result is being taken in the same
// cycle. Every sum saturates at the all-ones coordinate value. SIZE_BITS must
// not exceed COORD_BITS. The user writes configuration through the APB-style
// port only while no transaction is in flight; the block does not enforce it.
module greedy_wrap_layout_placer #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gwlp_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [gwlp_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [gwlp_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  // box input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SIZE_BITS-1:0]               box_width,
  input  logic [SIZE_BITS-1:0]               box_height,
  input  logic                               last_box,
  // placement output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [COORD_BITS-1:0]              place_x,
  output logic [COORD_BITS-1:0]              place_y,
  output logic                               layout_done,
  output logic [COORD_BITS-1:0]              total_width,
  output logic [COORD_BITS-1:0]              total_height
);

  localparam int unsigned CW = COORD_BITS;

  typedef logic [CW-1:0] coord_t;

  // Saturating add of two coordinates
  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CW] ? '1 : sum[CW-1:0];
  endfunction

  function automatic coord_t max_c(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  // Configuration registers
  logic                 orientation;
  logic                 stack_mode;
  coord_t               available_extent;
  logic [SIZE_BITS-1:0] spacing_x;
  logic [SIZE_BITS-1:0] spacing_y;

  gwlp_cfg #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .orientation      (orientation),
    .stack_mode       (stack_mode),
    .available_extent (available_extent),
    .spacing_x        (spacing_x),
    .spacing_y        (spacing_y)
  );

  // Layout state
  logic   at_first_box;
  coord_t line_length;
  coord_t line_thickness;
  coord_t cursor_cross;
  coord_t longest_line;

  coord_t line_length_next;
  coord_t line_thickness_next;
  coord_t cursor_cross_next;
  coord_t longest_line_next;

  logic   in_accept;
  coord_t size_main;
  coord_t size_cross;
  coord_t gap_main;
  coord_t gap_cross;
  coord_t start_pos;
  coord_t end_pos;
  coord_t cross_wrap;
  logic   wrap;
  coord_t pos_main;
  coord_t tot_main;
  coord_t tot_cross;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Map width/height and spacings onto main and cross axes
  assign size_main  = orientation ? CW'(box_height) : CW'(box_width);
  assign size_cross = orientation ? CW'(box_width)  : CW'(box_height);
  assign gap_main   = orientation ? CW'(spacing_y)  : CW'(spacing_x);
  assign gap_cross  = orientation ? CW'(spacing_x)  : CW'(spacing_y);

  // Candidate position on the current line and the wrap decision
  assign start_pos  = sat_add(line_length, gap_main);
  assign end_pos    = sat_add(start_pos, size_main);
  assign cross_wrap = sat_add(cursor_cross, sat_add(gap_cross, line_thickness));
  assign wrap       = !stack_mode && (end_pos > available_extent);

  // Next line state for this box
  always_comb begin
    if (at_first_box) begin
      pos_main            = '0;
      cursor_cross_next   = '0;
      line_length_next    = size_main;
      line_thickness_next = size_cross;
      longest_line_next   = size_main;
    end else if (wrap) begin
      pos_main            = '0;
      cursor_cross_next   = cross_wrap;
      line_length_next    = size_main;
      line_thickness_next = size_cross;
      longest_line_next   = max_c(longest_line, line_length);
    end else begin
      pos_main            = start_pos;
      cursor_cross_next   = cursor_cross;
      line_length_next    = end_pos;
      line_thickness_next = max_c(line_thickness, size_cross);
      longest_line_next   = longest_line;
    end
  end

  // Layout totals, used on the last box
  assign tot_main  = max_c(line_length_next, longest_line_next);
  assign tot_cross = sat_add(cursor_cross_next, line_thickness_next);

  // State update; the last box hands back a cleared layout
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_box   <= 1'b1;
      line_length    <= '0;
      line_thickness <= '0;
      cursor_cross   <= '0;
      longest_line   <= '0;
    end else if (in_accept) begin
      if (last_box) begin
        at_first_box   <= 1'b1;
        line_length    <= '0;
        line_thickness <= '0;
        cursor_cross   <= '0;
        longest_line   <= '0;
      end else begin
        at_first_box   <= 1'b0;
        line_length    <= line_length_next;
        line_thickness <= line_thickness_next;
        cursor_cross   <= cursor_cross_next;
        longest_line   <= longest_line_next;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      place_x      <= orientation ? cursor_cross_next : pos_main;
      place_y      <= orientation ? pos_main : cursor_cross_next;
      layout_done  <= last_box;
      total_width  <= last_box ? (orientation ? tot_cross : tot_main) : '0;
      total_height <= last_box ? (orientation ? tot_main : tot_cross) : '0;
    end
  end

  // A last box produces a done result and rearms the layout
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_box |=> out_valid && layout_done && at_first_box)
    else $error("last box did not produce a done result or rearm the layout");

  // Totals are only reported with the last box
  a_totals_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !layout_done |-> total_width == '0 && total_height == '0)
    else $error("totals reported on a box that is not last");

  // A fresh layout starts from a cleared line state
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    at_first_box |-> line_length == '0 && cursor_cross == '0 &&
                     line_thickness == '0 && longest_line == '0)
    else $error("layout state not cleared at first box");

  // A non-last box leaves the layout open
  a_open_layout: assert property (@(posedge clk) disable iff (rst)
    in_accept && !last_box |=> !at_first_box)
    else $error("layout closed without a last box");

endmodule

### verif/tb_greedy_wrap_layout_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_wrap_layout_placer: self-checking bench for the box layout placer
// Drives box transactions and APB register writes, predicts every placement
// with a scoreboard that tracks the line state, and checks each result
// transaction in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_greedy_wrap_layout_placer;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned SIZE_BITS  = 16;
  localparam logic [COORD_BITS-1:0] COORD_ALL = '1;
  localparam logic [SIZE_BITS-1:0]  SIZE_ALL  = '1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [gwlp_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   done;
    coord_t tw;
    coord_t th;
  } placement_t;

  // Scoreboard: mirrored registers, line state and the queue of placements
  class layout_scoreboard;
    bit         vert;
    bit         stack;
    coord_t     avail;
    size_t      gap_x;
    size_t      gap_y;
    bit         first;
    coord_t     line_len;
    coord_t     line_thick;
    coord_t     cross_pos;
    coord_t     longest;
    placement_t placements_q[$];
    int         errors;

    function new();
      vert   = 1'b1;
      stack  = 1'b0;
      avail  = COORD_ALL;
      gap_x  = '0;
      gap_y  = '0;
      errors = 0;
      clear_layout();
    endfunction

    function void clear_layout();
      first      = 1'b1;
      line_len   = '0;
      line_thick = '0;
      cross_pos  = '0;
      longest    = '0;
    endfunction

    function coord_t sat_sum(coord_t a, coord_t b);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_BITS] ? COORD_ALL : s[COORD_BITS-1:0];
    endfunction

    function void write_reg(gwlp_pkg::reg_idx_t idx, cfg_data_t value);
      case (idx)
        gwlp_pkg::REG_ORIENTATION:      vert  = value[0];
        gwlp_pkg::REG_STACK_MODE:       stack = value[0];
        gwlp_pkg::REG_AVAILABLE_EXTENT: avail = value[COORD_BITS-1:0];
        gwlp_pkg::REG_SPACING_X:        gap_x = value[SIZE_BITS-1:0];
        gwlp_pkg::REG_SPACING_Y:        gap_y = value[SIZE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return placements_q.size();
    endfunction

    // Place one accepted box and queue the expected result
    function void note_box(size_t w, size_t h, logic last);
      coord_t     sz_main;
      coord_t     sz_cross;
      coord_t     gp_main;
      coord_t     gp_cross;
      coord_t     start;
      coord_t     fin;
      coord_t     pos;
      coord_t     tot_main;
      coord_t     tot_cross;
      placement_t p;
      sz_main  = vert ? coord_t'(h) : coord_t'(w);
      sz_cross = vert ? coord_t'(w) : coord_t'(h);
      gp_main  = vert ? coord_t'(gap_y) : coord_t'(gap_x);
      gp_cross = vert ? coord_t'(gap_x) : coord_t'(gap_y);
      if (first) begin
        pos        = '0;
        cross_pos  = '0;
        line_len   = sz_main;
        line_thick = sz_cross;
        longest    = sz_main;
        first      = 1'b0;
      end else begin
        start = sat_sum(line_len, gp_main);
        fin   = sat_sum(start, sz_main);
        if (!stack && fin > avail) begin
          // wrap: close the line and open a new one with this box
          if (line_len > longest) longest = line_len;
          cross_pos  = sat_sum(cross_pos, sat_sum(gp_cross, line_thick));
          line_thick = sz_cross;
          line_len   = sz_main;
          pos        = '0;
        end else begin
          if (sz_cross > line_thick) line_thick = sz_cross;
          line_len = fin;
          pos      = start;
        end
      end
      p.x    = vert ? cross_pos : pos;
      p.y    = vert ? pos : cross_pos;
      p.done = last;
      p.tw   = '0;
      p.th   = '0;
      if (last) begin
        tot_main  = (line_len > longest) ? line_len : longest;
        tot_cross = sat_sum(cross_pos, line_thick);
        p.tw      = vert ? tot_cross : tot_main;
        p.th      = vert ? tot_main : tot_cross;
        clear_layout();
      end
      placements_q = {placements_q, p};
    endfunction

    function void compare_field(string field, coord_t want, coord_t got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare one result transaction against the oldest placement
    function void check_placement(coord_t x, coord_t y, logic done, coord_t tw, coord_t th);
      placement_t want;
      if (placements_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual x=%0d y=%0d done=%0b",
                 $time, x, y, done);
        errors++;
        return;
      end
      want = placements_q.pop_front();
      compare_field("place_x", want.x, x);
      compare_field("place_y", want.y, y);
      compare_field("layout_done", coord_t'(want.done), coord_t'(done));
      compare_field("total_width", want.tw, tw);
      compare_field("total_height", want.th, th);
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [gwlp_pkg::CFG_ADDR_BITS-1:0] paddr;
  cfg_data_t                          pwdata;
  cfg_data_t                          prdata;
  logic                               pready;
  logic                               in_valid;
  logic                               in_stall;
  size_t                              box_width;
  size_t                              box_height;
  logic                               last_box;
  logic                               out_valid;
  logic                               out_stall;
  coord_t                             place_x;
  coord_t                             place_y;
  logic                               layout_done;
  coord_t                             total_width;
  coord_t                             total_height;

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  layout_scoreboard sb = new();

  greedy_wrap_layout_placer #(
    .COORD_BITS(COORD_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .box_width   (box_width),
    .box_height  (box_height),
    .last_box    (last_box),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .place_x     (place_x),
    .place_y     (place_y),
    .layout_done (layout_done),
    .total_width (total_width),
    .total_height(total_height)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // APB write: setup cycle, access cycle, then a return to idle
  task automatic reg_write(gwlp_pkg::reg_idx_t idx, cfg_data_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gwlp_pkg::CFG_ADDR_BITS'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_setup(bit o, bit s, coord_t a, size_t sx, size_t sy);
    reg_write(gwlp_pkg::REG_ORIENTATION, cfg_data_t'(o));
    reg_write(gwlp_pkg::REG_STACK_MODE, cfg_data_t'(s));
    reg_write(gwlp_pkg::REG_AVAILABLE_EXTENT, cfg_data_t'(a));
    reg_write(gwlp_pkg::REG_SPACING_X, cfg_data_t'(sx));
    reg_write(gwlp_pkg::REG_SPACING_Y, cfg_data_t'(sy));
  endtask

  // Offer one box transaction and hold it until accepted
  task automatic send_box(size_t w, size_t h, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    box_width  <= w;
    box_height <= h;
    last_box   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_box(w, h, last);
  endtask

  // Stop offering and wait for every placement to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic size_t pick_size(bit big);
    if (big) return ($urandom_range(0, 3) == 0) ? size_t'($urandom_range(16'hF000, 16'hFFFF))
                                                 : SIZE_ALL;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SIZE_ALL;
      2, 3:    return size_t'($urandom);
      default: return size_t'($urandom_range(0, 5000));
    endcase
  endfunction

  // Result side: check accepted results, random stall bursts, long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_placement(place_x, place_y, layout_done, total_width, total_height);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed cases, random phases, end check
  initial begin
    int     p;
    int     i;
    int     n;
    int     boxes_left;
    bit     sat;
    coord_t avail;
    size_t  sx;
    size_t  sy;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    box_width  <= '0;
    box_height <= '0;
    last_box   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: vertical wrap, full extent, no spacing
    send_box(16'd0, 16'd0, 1'b1);
    send_box(SIZE_ALL, SIZE_ALL, 1'b0);
    send_box(SIZE_ALL, 16'd1234, 1'b1);
    drain();

    // horizontal wrap with spacing: fit, wrap, oversized box on a later line
    apply_setup(1'b0, 1'b0, 24'd100, 16'd10, 16'd5);
    send_box(16'd40, 16'd20, 1'b0);
    send_box(16'd40, 16'd30, 1'b0);
    send_box(16'd30, 16'd10, 1'b0);
    send_box(16'd200, 16'd5, 1'b0);
    send_box(16'd10, 16'd10, 1'b1);
    // oversized first box stays on the first line
    send_box(16'd150, 16'd10, 1'b0);
    send_box(16'd5, 16'd5, 1'b0);
    drain();
    // register change in the middle of a layout
    reg_write(gwlp_pkg::REG_AVAILABLE_EXTENT, cfg_data_t'(COORD_ALL));
    send_box(16'd5, 16'd5, 1'b0);
    send_box(16'd7, 16'd7, 1'b1);
    drain();

    // vertical stack
    apply_setup(1'b1, 1'b1, 24'd50, 16'd3, SIZE_ALL);
    send_box(16'd10, 16'd20, 1'b0);
    send_box(16'd30, 16'd40, 1'b0);
    send_box(SIZE_ALL, SIZE_ALL, 1'b1);
    drain();

    // zero extent: zero-size boxes still fit, anything else wraps
    apply_setup(1'b1, 1'b0, 24'd0, 16'd0, 16'd0);
    send_box(16'd0, 16'd0, 1'b0);
    send_box(16'd0, 16'd0, 1'b0);
    send_box(16'd1, 16'd1, 1'b0);
    send_box(16'd0, 16'd5, 1'b1);
    drain();

    // random phases; two drive coordinates into saturation
    boxes_left = 0;
    for (p = 0; p < 12; p++) begin
      quiet = (p >= 10);
      sat   = (p == 4 || p == 7);
      if (p == 4) begin
        apply_setup(1'b0, 1'b1, COORD_ALL, SIZE_ALL, SIZE_ALL);
      end else if (p == 7) begin
        apply_setup(1'b1, 1'b0, 24'd0, SIZE_ALL, SIZE_ALL);
      end else begin
        case ($urandom_range(0, 4))
          0:       avail = '0;
          1:       avail = COORD_ALL;
          2:       avail = coord_t'($urandom);
          default: avail = coord_t'($urandom_range(0, 400000));
        endcase
        case ($urandom_range(0, 3))
          0:       sx = '0;
          1:       sx = SIZE_ALL;
          2:       sx = size_t'($urandom);
          default: sx = size_t'($urandom_range(0, 64));
        endcase
        case ($urandom_range(0, 3))
          0:       sy = '0;
          1:       sy = SIZE_ALL;
          2:       sy = size_t'($urandom);
          default: sy = size_t'($urandom_range(0, 64));
        endcase
        apply_setup(1'($urandom), ($urandom_range(0, 3) == 0), avail, sx, sy);
      end
      // long receiver hold-off while boxes keep coming
      if (p == 1) hold_req = 1'b1;
      n = sat ? 150 : 100;
      if (sat) boxes_left = $urandom_range(130, 150);
      for (i = 0; i < n; i++) begin
        if (boxes_left == 0) boxes_left = sat ? $urandom_range(130, 150) : $urandom_range(1, 12);
        send_box(pick_size(sat), pick_size(sat), boxes_left == 1);
        boxes_left--;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
